// ===== rtl/ove_pkg.sv =====
`timescale 1ns / 1ps

package ove_pkg;

    // Component width of the input vector
    localparam int COMP_BITS = 16;

    // Magnitude of one component, and the L1 norm of three of them
    localparam int MAG_W = COMP_BITS;
    localparam int L1_W  = COMP_BITS + 1;

    // SNORM16: quotient is 15 bits, the scale is 2**Q_W - 1
    localparam int Q_W   = 15;
    localparam int ENC_W = Q_W + 1;

    // Dividend 2*scale*num + den, divisor 2*den
    localparam int NUM_W = L1_W + Q_W + 1;
    localparam int DEN_W = L1_W + 1;

    // Pipeline: three setup stages, one stage per quotient bit, one output stage
    localparam int PREP_STAGES = 3;
    localparam int PIPE_DEPTH  = PREP_STAGES + Q_W + 1;

    typedef logic [NUM_W-1:0] t_rem;
    typedef logic [DEN_W-1:0] t_den;
    typedef logic [Q_W-1:0]   t_quo;

    // Per-item control that rides alongside the divider lanes
    typedef struct packed {
        logic tangent;
        logic hneg;
        logic neg_u;
        logic neg_v;
        logic zero;
    } t_side;

endpackage

// ===== rtl/octahedral_vector_encoder.sv =====
`timescale 1ns / 1ps

// Octahedral vector encoder, SNORM16 output.
// Input channel: i_valid / o_ready carry one vector beat (request type, three
// signed components, handedness). Output channel: o_valid / i_ready carry one
// result beat (enc_u, enc_v, zero_vector) per input beat, in order.
// An accepted input beat passes 3 setup stages, 15 divider stages at one
// quotient bit each and 1 output stage before its result reaches the output.
// Throughput: one beat per cycle while the receiver does not stall; the two
// restoring divider lanes are fully pipelined, one stage per quotient bit.
// Reset (synchronous, active low) clears every stage valid bit; the pipeline
// comes out of reset empty with o_ready high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_ready drops; nothing is lost or repeated. Empty slots ahead of the output
// stage are not squeezed out during a stall.
// Zero vectors give zeros and zero_vector = 1, also for tangent requests.
module octahedral_vector_encoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_req_type,
    input  logic signed [ove_pkg::COMP_BITS-1:0] i_comp_x,
    input  logic signed [ove_pkg::COMP_BITS-1:0] i_comp_y,
    input  logic signed [ove_pkg::COMP_BITS-1:0] i_comp_z,
    input  logic                                 i_handed_negative,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ove_pkg::ENC_W-1:0]     o_enc_u,
    output logic signed [ove_pkg::ENC_W-1:0]     o_enc_v,
    output logic                                 o_zero_vector
);

    localparam int QW    = ove_pkg::Q_W;
    localparam int EW    = ove_pkg::ENC_W;
    localparam int DEPTH = ove_pkg::PIPE_DEPTH;
    localparam int LAST_DIV = ove_pkg::PREP_STAGES + QW - 1;

    logic             w_adv;
    logic [DEPTH-1:0] r_vld;

    ove_pkg::t_rem  w_prep_rem_u, w_prep_rem_v;
    ove_pkg::t_den  w_prep_den;
    ove_pkg::t_side w_prep_side;

    ove_pkg::t_rem  w_rem_u [QW+1];
    ove_pkg::t_rem  w_rem_v [QW+1];
    ove_pkg::t_quo  w_quo_u [QW+1];
    ove_pkg::t_quo  w_quo_v [QW+1];
    ove_pkg::t_den  w_den   [QW];
    ove_pkg::t_den  r_den   [QW];
    ove_pkg::t_side r_side  [QW];

    logic [EW-1:0]  w_mag_u, w_mag_v;
    logic [EW-1:0]  n_enc_u, n_enc_v;
    logic           n_zero;
    logic [EW-1:0]  r_enc_u, r_enc_v;
    logic           r_zero;

    // Pipeline moves when the output slot is free or being taken
    assign w_adv   = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[DEPTH-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // Magnitudes, L1 norm, dividend and divisor
    ove_prep u_prep (
        .i_clk             (i_clk),
        .i_en              (w_adv),
        .i_req_type        (i_req_type),
        .i_comp_x          (i_comp_x),
        .i_comp_y          (i_comp_y),
        .i_comp_z          (i_comp_z),
        .i_handed_negative (i_handed_negative),
        .o_rem_u           (w_prep_rem_u),
        .o_rem_v           (w_prep_rem_v),
        .o_den             (w_prep_den),
        .o_side            (w_prep_side)
    );

    assign w_rem_u[0] = w_prep_rem_u;
    assign w_rem_v[0] = w_prep_rem_v;
    assign w_quo_u[0] = '0;
    assign w_quo_v[0] = '0;

    // Divider lanes, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        if (k == 0) begin : g_first
            assign w_den[k] = w_prep_den;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_side[k] <= w_prep_side;
                end
            end
        end else begin : g_next
            assign w_den[k] = r_den[k-1];
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_den[k] <= w_den[k];
            end
        end

        ove_div_step u_step_u (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rem (w_rem_u[k]),
            .i_quo (w_quo_u[k]),
            .i_den (w_den[k]),
            .o_rem (w_rem_u[k+1]),
            .o_quo (w_quo_u[k+1])
        );

        ove_div_step u_step_v (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rem (w_rem_v[k]),
            .i_quo (w_quo_v[k]),
            .i_den (w_den[k]),
            .o_rem (w_rem_v[k+1]),
            .o_quo (w_quo_v[k+1])
        );
    end

    // Sign, tangent bit and zero-vector override
    always_comb begin
        w_mag_u = {1'b0, w_quo_u[QW]};
        w_mag_v = {1'b0, w_quo_v[QW]};
        n_enc_u = r_side[QW-1].neg_u ? (EW'(0) - w_mag_u) : w_mag_u;
        n_enc_v = r_side[QW-1].neg_v ? (EW'(0) - w_mag_v) : w_mag_v;
        if (r_side[QW-1].tangent) begin
            n_enc_u[0] = r_side[QW-1].hneg;
        end
        n_zero = r_side[QW-1].zero;
        if (n_zero) begin
            n_enc_u = '0;
            n_enc_v = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_enc_u <= n_enc_u;
            r_enc_v <= n_enc_v;
            r_zero  <= n_zero;
        end
    end

    assign o_enc_u       = r_enc_u;
    assign o_enc_v       = r_enc_v;
    assign o_zero_vector = r_zero;

`ifndef SYNTHESIS
    // Final remainder stays below the divisor: the quotient is complete
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST_DIV] && !r_side[QW-1].zero
        |-> (w_rem_u[QW] < ove_pkg::NUM_W'({r_den[QW-1], {QW{1'b0}}}))
         && (w_rem_v[QW] < ove_pkg::NUM_W'({r_den[QW-1], {QW{1'b0}}})))
        else $error("divider remainder out of range");

    // Zero vector forces both coordinates to zero
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_vector |-> (o_enc_u == '0) && (o_enc_v == '0))
        else $error("zero vector with nonzero coordinates");

    // A held result advances the pipeline only when it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_vld))
        else $error("pipeline moved during output stall");
`endif

endmodule

// ===== rtl/ove_prep.sv =====
`timescale 1ns / 1ps

module ove_prep (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic                                 i_req_type,
    input  logic signed [ove_pkg::COMP_BITS-1:0] i_comp_x,
    input  logic signed [ove_pkg::COMP_BITS-1:0] i_comp_y,
    input  logic signed [ove_pkg::COMP_BITS-1:0] i_comp_z,
    input  logic                                 i_handed_negative,
    output ove_pkg::t_rem                        o_rem_u,
    output ove_pkg::t_rem                        o_rem_v,
    output ove_pkg::t_den                        o_den,
    output ove_pkg::t_side                       o_side
);

    localparam int MW = ove_pkg::MAG_W;
    localparam int LW = ove_pkg::L1_W;
    localparam int NW = ove_pkg::NUM_W;
    localparam int DW = ove_pkg::DEN_W;
    localparam int QW = ove_pkg::Q_W;
    localparam int CB = ove_pkg::COMP_BITS;

    // Stage 1: magnitudes and signs
    logic [MW-1:0]   r_ax, r_ay, r_az;
    logic            r_zneg1;
    ove_pkg::t_side  r_side1;
    logic [MW-1:0]   n_ax, n_ay, n_az;
    ove_pkg::t_side  n_side1;

    // Stage 2: L1 norm and folded numerators
    logic [LW-1:0]   r_l1, r_num_u, r_num_v;
    ove_pkg::t_side  r_side2;
    logic [LW-1:0]   n_l1, n_num_u, n_num_v;

    // Stage 3: dividend and divisor
    ove_pkg::t_rem   r_rem_u, r_rem_v;
    ove_pkg::t_den   r_den;
    ove_pkg::t_side  r_side3;
    ove_pkg::t_rem   n_rem_u, n_rem_v;
    ove_pkg::t_den   n_den;

    always_comb begin
        n_ax = i_comp_x[CB-1] ? MW'(-i_comp_x) : MW'(i_comp_x);
        n_ay = i_comp_y[CB-1] ? MW'(-i_comp_y) : MW'(i_comp_y);
        n_az = i_comp_z[CB-1] ? MW'(-i_comp_z) : MW'(i_comp_z);
        n_side1.tangent = i_req_type;
        n_side1.hneg    = i_handed_negative;
        n_side1.neg_u   = i_comp_x[CB-1];
        n_side1.neg_v   = i_comp_y[CB-1];
        n_side1.zero    = (i_comp_x == '0) && (i_comp_y == '0) && (i_comp_z == '0);
    end

    // Lower hemisphere: l1 - |y| = |x| + |z|, l1 - |x| = |y| + |z|
    always_comb begin
        n_l1    = LW'(r_ax) + LW'(r_ay) + LW'(r_az);
        n_num_u = r_zneg1 ? (LW'(r_ax) + LW'(r_az)) : LW'(r_ax);
        n_num_v = r_zneg1 ? (LW'(r_ay) + LW'(r_az)) : LW'(r_ay);
    end

    // N = 2*(2**QW - 1)*num + l1, D = 2*l1
    always_comb begin
        n_rem_u = (NW'(r_num_u) << (QW + 1)) - (NW'(r_num_u) << 1) + NW'(r_l1);
        n_rem_v = (NW'(r_num_v) << (QW + 1)) - (NW'(r_num_v) << 1) + NW'(r_l1);
        n_den   = {r_l1, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_az    <= n_az;
            r_zneg1 <= i_comp_z[CB-1];
            r_side1 <= n_side1;
            r_l1    <= n_l1;
            r_num_u <= n_num_u;
            r_num_v <= n_num_v;
            r_side2 <= r_side1;
            r_rem_u <= n_rem_u;
            r_rem_v <= n_rem_v;
            r_den   <= DW'(n_den);
            r_side3 <= r_side2;
        end
    end

    assign o_rem_u = r_rem_u;
    assign o_rem_v = r_rem_v;
    assign o_den   = r_den;
    assign o_side  = r_side3;

endmodule

// ===== rtl/ove_div_step.sv =====
`timescale 1ns / 1ps

module ove_div_step (
    input  logic          i_clk,
    input  logic          i_en,
    input  ove_pkg::t_rem i_rem,
    input  ove_pkg::t_quo i_quo,
    input  ove_pkg::t_den i_den,
    output ove_pkg::t_rem o_rem,
    output ove_pkg::t_quo o_quo
);

    localparam int NW = ove_pkg::NUM_W;
    localparam int QW = ove_pkg::Q_W;

    ove_pkg::t_rem w_trial;
    ove_pkg::t_rem w_diff;
    logic          w_ge;
    ove_pkg::t_rem n_rem;
    ove_pkg::t_quo n_quo;
    ove_pkg::t_rem r_rem;
    ove_pkg::t_quo r_quo;

    // Restoring step: divisor stays aligned to the top quotient bit,
    // the partial remainder shifts up one place per stage
    always_comb begin
        w_trial = NW'({i_den, {(QW - 1){1'b0}}});
        w_ge    = (i_rem >= w_trial);
        w_diff  = w_ge ? (i_rem - w_trial) : i_rem;
        n_rem   = {w_diff[NW-2:0], 1'b0};
        n_quo   = {i_quo[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule
